FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the unpacker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

// Implication checked on every clock edge, reset included.
`define CHK_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hdl/forbu_pkg.sv
// Package of the frame-of-reference bit unpacker: constants and shared types.
`default_nettype none

package forbu_pkg;

  // Width of the value counters
  localparam int COUNT_BITS = 24;
  // Bit buffer width: up to 31 held bits plus one byte
  localparam int BUF_BITS   = 40;
  localparam int WIDTH_MAX  = 32;
  // Depth of the byte queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Register indexes of the configuration port
  localparam logic [2:0] REG_BIT_WIDTH   = 3'd0;
  localparam logic [2:0] REG_VALUE_COUNT = 3'd1;
  localparam logic [2:0] REG_BASE_VALUE  = 3'd2;
  localparam logic [2:0] REG_NARROW_16   = 3'd3;

  // One slot presented by the byte queue
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_slot_t;

  // One configuration write
  typedef struct packed {
    logic        write;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_write_t;

endpackage

`default_nettype wire

FILE: hdl/forbu_front.sv
// Front part: accepts packed bytes and holds them in a short queue.
`default_nettype none

module forbu_front
  import forbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output byte_slot_t head,
  input  logic       pop
);

  logic [7:0]           slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic                 push;
  logic                 take;

  // Stall only on a full queue, taken from a register
  assign in_stall = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign take     = pop && head.valid;

  assign head.valid = (fill != '0);
  assign head.data  = slots[rd_ptr];

  // Byte storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_byte;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !take) begin
        fill <= fill + (QPTR_BITS+1)'(1);
      end else if (take && !push) begin
        fill <= fill - (QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/forbu_back.sv
// Back part: bit buffer, field extraction, base add and output register.
`default_nettype none

module forbu_back
  import forbu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_write_t         cfg,
  input  byte_slot_t         head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               last_of_byte,
  output logic               block_end
);

  // Configuration registers
  logic [5:0]            bit_width;
  logic [COUNT_BITS-1:0] value_count;
  logic [31:0]           base_value;
  logic                  narrow_16;

  // Unpacking state
  logic [BUF_BITS-1:0]   bit_buffer;
  logic [5:0]            bits_held;
  logic [COUNT_BITS-1:0] values_given;

  logic [5:0]            w;
  logic                  complete;
  logic                  merge;
  logic                  out_free;
  logic                  emit;
  logic [BUF_BITS-1:0]   cur_buf;
  logic [5:0]            cur_held;
  logic [WIDTH_MAX:0]    fmask;
  logic [31:0]           sum;
  logic [31:0]           result;
  logic [COUNT_BITS-1:0] given_next;
  logic [5:0]            held_left;
  logic [BUF_BITS-1:0]   buffer_next;
  logic [5:0]            held_next;

  // Width clamped to 1..32
  always_comb begin
    if (bit_width == 6'd0) begin
      w = 6'd1;
    end else if (bit_width > 6'(WIDTH_MAX)) begin
      w = 6'(WIDTH_MAX);
    end else begin
      w = bit_width;
    end
  end

  // Byte intake: drop once the block is complete, append when short of a field
  assign complete = (values_given >= value_count);
  assign merge    = head.valid && !complete && (bits_held < w);
  assign pop      = head.valid && (complete || (bits_held < w));

  always_comb begin
    if (merge) begin
      cur_buf  = bit_buffer | (BUF_BITS'(head.data) << bits_held);
      cur_held = bits_held + 6'd8;
    end else begin
      cur_buf  = bit_buffer;
      cur_held = bits_held;
    end
  end

  // Field extraction and frame-of-reference add
  assign out_free   = !out_valid || !out_stall;
  assign emit       = !complete && (cur_held >= w) && out_free;
  assign fmask      = ((WIDTH_MAX+1)'(1) << w) - (WIDTH_MAX+1)'(1);
  assign sum        = (cur_buf[31:0] & fmask[31:0]) + base_value;
  assign result     = narrow_16 ? {{16{sum[15]}}, sum[15:0]} : sum;
  assign given_next = values_given + COUNT_BITS'(1);
  assign held_left  = cur_held - w;

  always_comb begin
    if (emit) begin
      buffer_next = cur_buf >> w;
      held_next   = held_left;
    end else begin
      buffer_next = cur_buf;
      held_next   = cur_held;
    end
  end

  // Configuration and unpacking state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width    <= 6'd8;
      value_count  <= '0;
      base_value   <= '0;
      narrow_16    <= 1'b0;
      bit_buffer   <= '0;
      bits_held    <= '0;
      values_given <= '0;
    end else if (cfg.write) begin
      case (cfg.index)
        REG_BIT_WIDTH: begin
          bit_width  <= cfg.data[5:0];
          bit_buffer <= '0;
          bits_held  <= '0;
        end
        REG_VALUE_COUNT: begin
          value_count  <= cfg.data[COUNT_BITS-1:0];
          values_given <= '0;
          bit_buffer   <= '0;
          bits_held    <= '0;
        end
        REG_BASE_VALUE: begin
          base_value <= cfg.data;
        end
        REG_NARROW_16: begin
          narrow_16 <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end else begin
      bit_buffer <= buffer_next;
      bits_held  <= held_next;
      if (emit) begin
        values_given <= given_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value        <= signed'(result);
      block_end    <= (given_next >= value_count);
      last_of_byte <= (held_left < w) || (given_next >= value_count);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/frame_of_reference_bit_unpacker_unit.sv
// Top level of the frame-of-reference bit unpacker.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  data_byte
//   output   out        out_valid/out_stall  value, last_of_byte, block_end
//   config   in         cfg_write            cfg_index, cfg_data
//
// One byte enters per cycle through a four-entry queue; the back part merges a
// byte and gives one value in the same cycle, so widths of 8 and above run
// at one byte per cycle. Below 8 bits the single output register sets the
// pace: no byte is taken while a field is held, so the queue stalls the input.
// rst (synchronous) empties the queue, clears the buffer and loads defaults.
// Output stalls hold the result register; the back part waits, the queue fills.
`default_nettype none

module frame_of_reference_bit_unpacker_unit
  import forbu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               last_of_byte,
  output logic               block_end
);

  byte_slot_t head;
  cfg_write_t cfg;
  logic       pop;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  forbu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .head      (head),
    .pop       (pop)
  );

  forbu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .last_of_byte (last_of_byte),
    .block_end    (block_end)
  );

endmodule

`default_nettype wire

FILE: hdl/forbu_checker.sv
// Port-level checks of the unpacker and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module forbu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] value,
  input logic        last_of_byte,
  input logic        block_end
);

  // A stalled result stays offered
  `CHK_IMPL(a_out_hold, out_valid && out_stall, out_valid)
  // A stalled result keeps its payload
  `CHK_IMPL(a_out_stable, out_valid && out_stall,
            $stable(value) && $stable(last_of_byte) && $stable(block_end))
  // Nothing follows the final value of a block at once
  `CHK_IMPL(a_end_quiet, out_valid && block_end && !out_stall, !out_valid)
  // Reset leaves an empty queue and no result
  `CHK_ALWAYS(a_reset, rst, !out_valid && !in_stall)

endmodule

bind frame_of_reference_bit_unpacker_unit forbu_checker u_forbu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .value        (value),
  .last_of_byte (last_of_byte),
  .block_end    (block_end)
);

`default_nettype wire

FILE: tb/tb_frame_of_reference_bit_unpacker_unit.sv
// Self-checking testbench of the frame-of-reference bit unpacker.
`default_nettype none

module tb_frame_of_reference_bit_unpacker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import forbu_pkg::*;

  // Cycles allowed for bytes that give no value to leave the queue and back part
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [31:0] value;
    logic        last_of_byte;
    logic        block_end;
  } unpacked_value_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         data_byte;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] value;
  logic               last_of_byte;
  logic               block_end;

  // Predictor state: register copies and the unpacking buffer
  logic [5:0]  fw_code;
  logic [23:0] count_limit;
  logic [31:0] base_offset;
  logic        narrow_mode;
  logic [39:0] bit_store;
  int          bits_in_store;
  logic [23:0] values_out;

  unpacked_value_t expected_values[$];
  unpacked_value_t head;

  int mismatches;
  int values_checked;
  int bytes_sent;
  int settings_written;
  bit idle_on;
  bit hold_req;

  frame_of_reference_bit_unpacker_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .last_of_byte (last_of_byte),
    .block_end    (block_end)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Safety net against a hung handshake
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("tb mismatch at value %0d: %s", values_checked, what);
    mismatches++;
  endtask

  // Mostly short pauses, now and then a long one
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom());
  endfunction

  // Width codes of 0 and above 32 are clamped
  function automatic int eff_width(input logic [5:0] code);
    if (code == 6'd0) return 1;
    if (code > 6'd32) return 32;
    return int'(code);
  endfunction

  // Append one byte to the buffer and queue every value it completes
  task automatic unpack_byte(input logic [7:0] b);
    unpacked_value_t batch[8];
    int          w;
    int          n;
    logic [31:0] field_mask;
    logic [31:0] sum;
    w = eff_width(fw_code);
    field_mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    n = 0;
    // finished block: byte is swallowed
    if (values_out < count_limit) begin
      bit_store = bit_store | ({32'd0, b} << bits_in_store);
      bits_in_store += 8;
      while (bits_in_store >= w && values_out < count_limit && n < 8) begin
        sum = (bit_store[31:0] & field_mask) + base_offset;
        if (narrow_mode) sum = {{16{sum[15]}}, sum[15:0]};
        bit_store = bit_store >> w;
        bits_in_store -= w;
        values_out = values_out + 24'd1;
        batch[n].value = sum;
        batch[n].last_of_byte = 1'b0;
        batch[n].block_end = (values_out >= count_limit);
        n++;
      end
      if (n > 0) batch[n-1].last_of_byte = 1'b1;
      for (int i = 0; i < n; i++) expected_values.push_back(batch[i]);
    end
  endtask

  // One register write, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BIT_WIDTH: begin
        fw_code = data[5:0];
        bit_store = '0;
        bits_in_store = 0;
      end
      REG_VALUE_COUNT: begin
        count_limit = data[23:0];
        values_out = '0;
        bit_store = '0;
        bits_in_store = 0;
      end
      REG_BASE_VALUE: base_offset = data;
      REG_NARROW_16:  narrow_mode = data[0];
      default: ;
    endcase
    settings_written++;
  endtask

  // Offer one byte, wait for the transaction, then predict its values
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? pause_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    unpack_byte(b);
    bytes_sent++;
  endtask

  // Stop offering, let every expected value arrive, then let the pipeline settle
  task automatic wait_until_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_values.size() != 0) begin
      report_mismatch($sformatf("%0d expected values never arrived",
                                expected_values.size()));
      expected_values.delete();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pause_length() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value %h", value));
      end else begin
        head = expected_values.pop_front();
        if (value !== head.value)
          report_mismatch($sformatf("value %h, want %h", value, head.value));
        if (last_of_byte !== head.last_of_byte)
          report_mismatch($sformatf("last_of_byte %b, want %b", last_of_byte,
                                    head.last_of_byte));
        if (block_end !== head.block_end)
          report_mismatch($sformatf("block_end %b, want %b", block_end,
                                    head.block_end));
        values_checked++;
      end
    end
  end

  // Reset defaults: count of zero swallows bytes; then a short 8-bit block
  task automatic test_empty_block();
    send_byte(8'h3C);
    send_byte(8'hC3);
    wait_until_idle();
    write_reg(REG_VALUE_COUNT, 32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h55);
  endtask

  // Width and base extremes, narrow sign extension, clamped widths, unused index
  task automatic test_field_extremes();
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd1);
    write_reg(REG_VALUE_COUNT, 32'd16);
    write_reg(REG_BASE_VALUE, 32'h7FFF_FFFF);
    send_byte(8'hA5);
    send_byte(8'hFF);
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd32);
    write_reg(REG_VALUE_COUNT, 32'd1);
    write_reg(REG_BASE_VALUE, 32'h8000_0000);
    repeat (4) send_byte(8'hFF);
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd16);
    write_reg(REG_VALUE_COUNT, 32'd2);
    write_reg(REG_BASE_VALUE, 32'd0);
    write_reg(REG_NARROW_16, 32'd1);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'h80);
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd0);
    write_reg(REG_VALUE_COUNT, 32'd8);
    write_reg(REG_BASE_VALUE, 32'hFFFF_FFFF);
    write_reg(REG_NARROW_16, 32'd0);
    send_byte(8'h5A);
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd40);
    write_reg(REG_VALUE_COUNT, 32'd1);
    write_reg(REG_BASE_VALUE, 32'd1);
    write_reg(3'd5, 32'hFFFF_FFFF);
    repeat (4) send_byte(8'($urandom()));
  endtask

  // Width rewrite mid-block drops held bits but keeps the value count
  task automatic test_width_change();
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd5);
    write_reg(REG_VALUE_COUNT, 32'd4);
    write_reg(REG_BASE_VALUE, 32'd0);
    send_byte(8'hFF);
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd3);
    send_byte(8'hC7);
    send_byte(8'h0F);
  endtask

  // Long output hold at width 1 so the queue fills and the input stalls
  task automatic test_long_hold();
    wait_until_idle();
    write_reg(REG_BIT_WIDTH, 32'd1);
    write_reg(REG_VALUE_COUNT, 32'd1000);
    write_reg(REG_BASE_VALUE, $urandom());
    write_reg(REG_NARROW_16, 32'd0);
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_byte(random_byte());
    idle_on = 1'b1;
  endtask

  // One block with random settings: bytes to finish it plus up to three spare, at most 48
  task automatic run_random_block(output int sent);
    logic [5:0]  w_code;
    logic [23:0] n_vals;
    logic [31:0] base;
    int          needed;
    int          split_at;
    int          r;
    wait_until_idle();
    r = $urandom_range(0, 9);
    if (r <= 2) w_code = 6'($urandom_range(1, 7));
    else if (r <= 5) w_code = ($urandom_range(0, 1) != 0) ? 6'd8 : 6'd16;
    else if (r <= 8) w_code = 6'($urandom_range(9, 32));
    else w_code = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(33, 63));
    write_reg(REG_BIT_WIDTH, ($urandom() & 32'hFFFF_FFC0) | 32'(w_code));
    r = $urandom_range(0, 9);
    if (r == 0) n_vals = 24'd0;
    else if (r <= 7) n_vals = 24'($urandom_range(1, 40));
    else if (r == 8) n_vals = 24'hFF_FFFF;
    else n_vals = 24'($urandom());
    write_reg(REG_VALUE_COUNT, ($urandom() & 32'hFF00_0000) | 32'(n_vals));
    case ($urandom_range(0, 5))
      0: base = 32'd0;
      1: base = 32'h7FFF_FFFF;
      2: base = 32'h8000_0000;
      3: base = 32'hFFFF_FFFF;
      default: base = $urandom();
    endcase
    write_reg(REG_BASE_VALUE, base);
    write_reg(REG_NARROW_16, $urandom());
    if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(4, 7)), $urandom());
    needed = (int'(n_vals) * eff_width(w_code) + 7) / 8 + $urandom_range(0, 3);
    if (needed > 48) needed = 48;
    split_at = ($urandom_range(0, 4) == 0) ? needed / 2 : -1;
    for (int i = 0; i < needed; i++) begin
      if (i == split_at) begin
        wait_until_idle();
        write_reg(REG_BIT_WIDTH, 32'($urandom_range(1, 32)));
      end
      send_byte(random_byte());
    end
    sent = (n_vals == 24'd0) ? 0 : needed;
  endtask

  task automatic test_random_blocks(input int target, input bit with_idling);
    int total;
    int n;
    idle_on = with_idling;
    total = 0;
    while (total < target) begin
      run_random_block(n);
      total += n;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 32'd0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    values_checked = 0;
    bytes_sent = 0;
    settings_written = 0;
    // predictor starts from the register defaults
    fw_code = 6'd8;
    count_limit = '0;
    base_offset = '0;
    narrow_mode = 1'b0;
    bit_store = '0;
    bits_in_store = 0;
    values_out = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_block();
    test_field_extremes();
    test_width_change();
    test_long_hold();
    test_random_blocks(240, 1'b1);
    test_random_blocks(40, 1'b0);
    wait_until_idle();

    $display("tb run: %0d bytes taken, %0d values compared, %0d register writes",
             bytes_sent, values_checked, settings_written);
    $display("tb run: widths 1..32 and clamped codes, narrow and wide sums, empty, %s",
             "finished and re-sized blocks, one long output hold");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
